### design/i2c_slave_shadowed_register_file_unit_macros.svh
// Assertion helpers shared by the register file RTL.
`ifndef I2C_SLAVE_SHADOWED_REGISTER_FILE_UNIT_MACROS_SVH
`define I2C_SLAVE_SHADOWED_REGISTER_FILE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### design/i2c_srf_pkg.sv
package i2c_srf_pkg;

  // Host function codes
  typedef enum logic [2:0] {
    FN_WR_REQ   = 3'd0,
    FN_WR_DONE  = 3'd1,
    FN_RD_REQ   = 3'd2,
    FN_RD_DONE  = 3'd3,
    FN_STOP     = 3'd4,
    FN_LOCAL_WR = 3'd5,
    FN_ALERT    = 3'd6
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOD,
    ST_COPY,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_ALERT_WAIT,
    ST_DONE
  } state_e;

  localparam int unsigned MOD_W = 9;

  localparam logic [7:0]  CMD_START     = 8'h00;
  localparam logic [7:0]  CONST_START   = 8'h30;
  localparam int unsigned LIMIT_ADDR    = 'h48;
  localparam logic [15:0] LIMIT_DEFAULT = 16'd2000;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data_byte;
    logic [6:0] local_address;
    logic [7:0] alert_bits;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       alert_pin;
    logic       cmd_strobe;
    logic       save_constants;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] value;
    logic [MOD_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] rem;
  } mod_rsp_t;

endpackage

### design/i2c_srf_in_if.sv
interface i2c_srf_in_if;
  logic                  valid;
  logic                  ready;
  i2c_srf_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

### design/i2c_srf_out_if.sv
interface i2c_srf_out_if;
  logic                   valid;
  logic                   ready;
  i2c_srf_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

### design/i2c_slave_shadowed_register_file_unit.sv
// Channel   Role    Payload                                        Handshake
// req_i     sink    func, data_byte, local_address, alert_bits     valid/ready
// rsp_o     source  read_data, read_valid, alert_pin, cmd_strobe,  valid/ready
//                   save_constants
//
// Sequence: each transaction passes idle, execute and done; a pointer byte or local
// write also passes the shared remainder unit, a read passes it too and adds a row
// snapshot at a row boundary and a read of the staging RAM, and a stop copies one
// byte per cycle through the single RAM ports.
// Reset: no clearing pass; per-entry valid bits supply the reset contents.
// Stalls: a full result register still lets the next transaction in; its result
// waits in the done state until the register frees up.
`include "i2c_slave_shadowed_register_file_unit_macros.svh"

module i2c_slave_shadowed_register_file_unit #(
  parameter int unsigned STORE_BYTES  = 128,
  parameter int unsigned ROW_BYTES    = 16,
  parameter int unsigned ALERT_OFFSET = 88
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2c_srf_in_if.sink    req_i,
  i2c_srf_out_if.source rsp_o
);

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned CW = $clog2(STORE_BYTES + 1);
  localparam int unsigned MW = i2c_srf_pkg::MOD_W;

  localparam logic [AW-1:0] AIDX = AW'(ALERT_OFFSET % STORE_BYTES);
  localparam logic [AW-1:0] LIM0 = AW'(i2c_srf_pkg::LIMIT_ADDR % STORE_BYTES);
  localparam logic [AW-1:0] LIM1 = AW'((i2c_srf_pkg::LIMIT_ADDR + 1) % STORE_BYTES);

  // Sequencer and datapath state
  i2c_srf_pkg::state_e   state_q, state_d;
  i2c_srf_pkg::in_item_t item_q, item_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] mark_q, mark_d;
  logic          expect_q, expect_d;
  logic          pend_q, pend_d;
  logic          alert_q, alert_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] end_q, end_d;
  logic          seg2_q, seg2_d;
  logic          commit_q, commit_d;
  logic          wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic [7:0]    rd_q, rd_d;
  logic          rv_q, rv_d;
  logic          nc_q, nc_d;
  logic          sc_q, sc_d;
  i2c_srf_pkg::out_item_t res_q, res_d;
  logic          out_vld_q, out_vld_d;

  // Memories and their valid bits
  logic                   stg_we, shd_we;
  logic [AW-1:0]          stg_waddr, shd_waddr, stg_raddr, shd_raddr;
  logic [7:0]             stg_wdata, shd_wdata, stg_rdata, shd_rdata;
  logic [STORE_BYTES-1:0] stg_vld_q, shd_vld_q;
  logic                   stg_rvld_q, shd_rvld_q;
  logic [AW-1:0]          shd_raddr_q;
  logic [7:0]             stg_res, shd_res, shd_rst_val;

  i2c_srf_pkg::mod_req_t mod_req;
  i2c_srf_pkg::mod_rsp_t mod_rsp;

  logic          accept, slot_free, copy_busy, seg_done;
  logic [CW-1:0] ptr_inc;
  logic [AW-1:0] ptr_bump;
  logic [9:0]    row_sum;
  logic [CW-1:0] row_end;

  assign accept    = req_i.valid && req_i.ready;
  assign slot_free = !out_vld_q || rsp_o.ready;
  assign copy_busy = cnt_q < end_q;
  assign seg_done  = !copy_busy && !wr_pend_q;

  // Advance the pointer, wrapping at the store size
  assign ptr_inc  = CW'(ptr_q) + CW'(1);
  assign ptr_bump = (ptr_inc >= CW'(STORE_BYTES)) ? '0 : ptr_inc[AW-1:0];

  // Snapshot stops at the end of the store
  assign row_sum = 10'(ptr_q) + 10'(ROW_BYTES);
  assign row_end = (row_sum > 10'(STORE_BYTES)) ? CW'(STORE_BYTES) : row_sum[CW-1:0];

  // Entries never written read as their reset value
  always_comb begin
    if (shd_raddr_q == LIM0) begin
      shd_rst_val = i2c_srf_pkg::LIMIT_DEFAULT[7:0];
    end else if (shd_raddr_q == LIM1) begin
      shd_rst_val = i2c_srf_pkg::LIMIT_DEFAULT[15:8];
    end else begin
      shd_rst_val = 8'h00;
    end
  end

  assign stg_res = stg_rvld_q ? stg_rdata : 8'h00;
  assign shd_res = shd_rvld_q ? shd_rdata : shd_rst_val;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      i2c_srf_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = i2c_srf_pkg::ST_EXEC;
        end
      end
      i2c_srf_pkg::ST_EXEC: begin
        unique case (item_q.func)
          i2c_srf_pkg::FN_WR_DONE: begin
            state_d = expect_q ? i2c_srf_pkg::ST_MOD : i2c_srf_pkg::ST_DONE;
          end
          i2c_srf_pkg::FN_RD_REQ, i2c_srf_pkg::FN_LOCAL_WR: begin
            state_d = i2c_srf_pkg::ST_MOD;
          end
          i2c_srf_pkg::FN_STOP: begin
            state_d = (pend_q && (mark_q != ptr_q)) ? i2c_srf_pkg::ST_COPY
                                                    : i2c_srf_pkg::ST_DONE;
          end
          i2c_srf_pkg::FN_ALERT: begin
            state_d = (item_q.alert_bits == 8'h00) ? i2c_srf_pkg::ST_DONE
                                                   : i2c_srf_pkg::ST_ALERT_WAIT;
          end
          default: begin
            state_d = i2c_srf_pkg::ST_DONE;
          end
        endcase
      end
      i2c_srf_pkg::ST_MOD: begin
        if (mod_rsp.done) begin
          if (item_q.func == i2c_srf_pkg::FN_RD_REQ) begin
            state_d = (mod_rsp.rem == '0) ? i2c_srf_pkg::ST_COPY : i2c_srf_pkg::ST_RD_ISSUE;
          end else begin
            state_d = i2c_srf_pkg::ST_DONE;
          end
        end
      end
      i2c_srf_pkg::ST_COPY: begin
        if (seg_done && !seg2_q) begin
          state_d = commit_q ? i2c_srf_pkg::ST_DONE : i2c_srf_pkg::ST_RD_ISSUE;
        end
      end
      i2c_srf_pkg::ST_RD_ISSUE:   state_d = i2c_srf_pkg::ST_RD_WAIT;
      i2c_srf_pkg::ST_RD_WAIT:    state_d = i2c_srf_pkg::ST_DONE;
      i2c_srf_pkg::ST_ALERT_WAIT: state_d = i2c_srf_pkg::ST_DONE;
      i2c_srf_pkg::ST_DONE: begin
        if (slot_free) begin
          state_d = i2c_srf_pkg::ST_IDLE;
        end
      end
      default: state_d = i2c_srf_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    item_d    = item_q;
    ptr_d     = ptr_q;
    mark_d    = mark_q;
    expect_d  = expect_q;
    pend_d    = pend_q;
    alert_d   = alert_q;
    cnt_d     = cnt_q;
    end_d     = end_q;
    seg2_d    = seg2_q;
    commit_d  = commit_q;
    wr_pend_d = 1'b0;
    wr_addr_d = wr_addr_q;
    rd_d      = rd_q;
    rv_d      = rv_q;
    nc_d      = nc_q;
    sc_d      = sc_q;
    res_d     = res_q;
    out_vld_d = out_vld_q && !rsp_o.ready;

    stg_we    = 1'b0;
    stg_waddr = ptr_q;
    stg_wdata = item_q.data_byte;
    stg_raddr = cnt_q[AW-1:0];
    shd_we    = 1'b0;
    shd_waddr = wr_addr_q;
    shd_wdata = stg_res;
    shd_raddr = cnt_q[AW-1:0];

    mod_req.start   = 1'b0;
    mod_req.value   = MW'(item_q.data_byte);
    mod_req.divisor = MW'(STORE_BYTES);

    unique case (state_q)
      i2c_srf_pkg::ST_IDLE: begin
        if (accept) begin
          item_d = req_i.item;
          rd_d   = 8'h00;
          rv_d   = 1'b0;
          nc_d   = 1'b0;
          sc_d   = 1'b0;
        end
      end
      i2c_srf_pkg::ST_EXEC: begin
        unique case (item_q.func)
          i2c_srf_pkg::FN_WR_REQ: begin
            expect_d = 1'b1;
            pend_d   = 1'b0;
          end
          i2c_srf_pkg::FN_WR_DONE: begin
            if (expect_q) begin
              mod_req.start = 1'b1;
            end else begin
              // Stage the data byte and advance
              stg_we   = 1'b1;
              ptr_d    = ptr_bump;
              pend_d   = 1'b1;
              expect_d = 1'b0;
            end
          end
          i2c_srf_pkg::FN_RD_REQ: begin
            mod_req.start   = 1'b1;
            mod_req.value   = MW'(ptr_q);
            mod_req.divisor = MW'(ROW_BYTES);
          end
          i2c_srf_pkg::FN_STOP: begin
            if (pend_q) begin
              pend_d   = 1'b0;
              commit_d = 1'b1;
              nc_d     = (mark_q < ptr_q) && (MW'(mark_q) == MW'(i2c_srf_pkg::CMD_START));
              sc_d     = MW'(mark_q) == MW'(i2c_srf_pkg::CONST_START);
              if (mark_q < ptr_q) begin
                cnt_d  = CW'(mark_q);
                end_d  = CW'(ptr_q);
                seg2_d = 1'b0;
              end else begin
                // Wrapped range: low part first, then mark up to the end
                cnt_d  = '0;
                end_d  = CW'(ptr_q);
                seg2_d = 1'b1;
              end
            end
          end
          i2c_srf_pkg::FN_LOCAL_WR: begin
            mod_req.start = 1'b1;
            mod_req.value = MW'(item_q.local_address);
          end
          i2c_srf_pkg::FN_ALERT: begin
            if (item_q.alert_bits == 8'h00) begin
              shd_we    = 1'b1;
              shd_waddr = AIDX;
              shd_wdata = 8'h00;
              alert_d   = 1'b0;
            end else begin
              shd_raddr = AIDX;
            end
          end
          default: begin
          end
        endcase
      end
      i2c_srf_pkg::ST_MOD: begin
        if (mod_rsp.done) begin
          unique case (item_q.func)
            i2c_srf_pkg::FN_WR_DONE: begin
              ptr_d    = mod_rsp.rem[AW-1:0];
              mark_d   = mod_rsp.rem[AW-1:0];
              expect_d = 1'b0;
            end
            i2c_srf_pkg::FN_LOCAL_WR: begin
              shd_we    = 1'b1;
              shd_waddr = mod_rsp.rem[AW-1:0];
              shd_wdata = item_q.data_byte;
            end
            i2c_srf_pkg::FN_RD_REQ: begin
              // Row boundary: snapshot the shadow row first
              cnt_d    = CW'(ptr_q);
              end_d    = row_end;
              seg2_d   = 1'b0;
              commit_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      i2c_srf_pkg::ST_COPY: begin
        if (copy_busy) begin
          wr_pend_d = 1'b1;
          wr_addr_d = cnt_q[AW-1:0];
          cnt_d     = cnt_q + CW'(1);
        end
        if (commit_q) begin
          shd_we    = wr_pend_q;
          shd_waddr = wr_addr_q;
          shd_wdata = stg_res;
        end else begin
          stg_we    = wr_pend_q;
          stg_waddr = wr_addr_q;
          stg_wdata = shd_res;
        end
        if (seg_done && seg2_q) begin
          cnt_d  = CW'(mark_q);
          end_d  = CW'(STORE_BYTES);
          seg2_d = 1'b0;
        end
      end
      i2c_srf_pkg::ST_RD_ISSUE: begin
        stg_raddr = ptr_q;
      end
      i2c_srf_pkg::ST_RD_WAIT: begin
        rd_d   = stg_res;
        rv_d   = 1'b1;
        ptr_d  = ptr_bump;
        pend_d = 1'b0;
        if (MW'(ptr_q) == MW'(ALERT_OFFSET)) begin
          alert_d = 1'b0;
        end
      end
      i2c_srf_pkg::ST_ALERT_WAIT: begin
        shd_we    = 1'b1;
        shd_waddr = AIDX;
        shd_wdata = shd_res | item_q.alert_bits;
        alert_d   = 1'b1;
      end
      i2c_srf_pkg::ST_DONE: begin
        if (slot_free) begin
          res_d.read_data      = rd_q;
          res_d.read_valid     = rv_q;
          res_d.alert_pin      = alert_q;
          res_d.cmd_strobe     = nc_q;
          res_d.save_constants = sc_q;
          out_vld_d            = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= i2c_srf_pkg::ST_IDLE;
      ptr_q      <= '0;
      mark_q     <= '0;
      expect_q   <= 1'b0;
      pend_q     <= 1'b0;
      alert_q    <= 1'b0;
      cnt_q      <= '0;
      end_q      <= '0;
      seg2_q     <= 1'b0;
      commit_q   <= 1'b0;
      wr_pend_q  <= 1'b0;
      out_vld_q  <= 1'b0;
      stg_vld_q  <= '0;
      shd_vld_q  <= '0;
      stg_rvld_q <= 1'b0;
      shd_rvld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      mark_q     <= mark_d;
      expect_q   <= expect_d;
      pend_q     <= pend_d;
      alert_q    <= alert_d;
      cnt_q      <= cnt_d;
      end_q      <= end_d;
      seg2_q     <= seg2_d;
      commit_q   <= commit_d;
      wr_pend_q  <= wr_pend_d;
      out_vld_q  <= out_vld_d;
      stg_rvld_q <= stg_vld_q[stg_raddr];
      shd_rvld_q <= shd_vld_q[shd_raddr];
      if (stg_we) begin
        stg_vld_q[stg_waddr] <= 1'b1;
      end
      if (shd_we) begin
        shd_vld_q[shd_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    wr_addr_q   <= wr_addr_d;
    rd_q        <= rd_d;
    rv_q        <= rv_d;
    nc_q        <= nc_d;
    sc_q        <= sc_d;
    res_q       <= res_d;
    shd_raddr_q <= shd_raddr;
  end

  i2c_srf_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_staging (
    .clk_i  (clk_i),
    .we_i   (stg_we),
    .waddr_i(stg_waddr),
    .wdata_i(stg_wdata),
    .raddr_i(stg_raddr),
    .rdata_o(stg_rdata)
  );

  i2c_srf_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_shadow (
    .clk_i  (clk_i),
    .we_i   (shd_we),
    .waddr_i(shd_waddr),
    .wdata_i(shd_wdata),
    .raddr_i(shd_raddr),
    .rdata_o(shd_rdata)
  );

  i2c_srf_modunit u_modunit (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mod_req),
    .rsp_o (mod_rsp)
  );

  assign req_i.ready = state_q == i2c_srf_pkg::ST_IDLE;
  assign rsp_o.valid = out_vld_q;
  assign rsp_o.item  = res_q;

  `SRF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, accept, !req_i.ready, "ready after accept")
  `SRF_ASSERT_IMPL(a_ptr_range, clk_i, rst_ni, 1'b1, CW'(ptr_q) < CW'(STORE_BYTES), "pointer range")
  `SRF_ASSERT_IMPL(a_wr_in_copy, clk_i, rst_ni, wr_pend_q, state_q == i2c_srf_pkg::ST_COPY, "stray copy write")
  `SRF_ASSERT_IMPL(a_copy_bound, clk_i, rst_ni, state_q == i2c_srf_pkg::ST_COPY, end_q <= CW'(STORE_BYTES), "copy end")

endmodule

### design/i2c_srf_ram.sv
module i2c_srf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/i2c_srf_modunit.sv
// Iterative remainder: subtract the divisor once per cycle until below it.
module i2c_srf_modunit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  i2c_srf_pkg::mod_req_t req_i,
  output i2c_srf_pkg::mod_rsp_t rsp_o
);

  logic [i2c_srf_pkg::MOD_W-1:0] rem_q, rem_d;
  logic [i2c_srf_pkg::MOD_W-1:0] div_q, div_d;
  logic                          busy_q, busy_d;
  logic                          below;

  assign below = rem_q < div_q;

  always_comb begin
    rem_d  = rem_q;
    div_d  = div_q;
    busy_d = busy_q;
    if (req_i.start) begin
      rem_d  = req_i.value;
      div_d  = req_i.divisor;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (below) begin
        busy_d = 1'b0;
      end else begin
        rem_d = rem_q - div_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done = busy_q && below;
  assign rsp_o.rem  = rem_q;

endmodule

### dv/i2c_srf_reply_checker.sv
module i2c_srf_reply_checker #(
  parameter int unsigned STORE_BYTES  = 128,
  parameter int unsigned ROW_BYTES    = 16,
  parameter int unsigned ALERT_OFFSET = 88
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2c_srf_in_if         req_i,
  i2c_srf_out_if        rsp_i,
  output int unsigned   mismatches_o,
  output int unsigned   outstanding_o,
  output int unsigned   transactions_o,
  output int unsigned   reads_o,
  output int unsigned   cmd_pulses_o,
  output int unsigned   save_pulses_o
);
  import i2c_srf_pkg::*;

  // Mirror of the register file state
  logic [7:0]  staging_mem [STORE_BYTES];
  logic [7:0]  shadow_mem  [STORE_BYTES];
  int unsigned byte_ptr;
  int unsigned start_mark;
  bit          addr_phase;
  bit          commit_armed;
  bit          alert_line;

  out_item_t   pending_replies [$];

  function automatic int unsigned next_ptr(input int unsigned p);
    return (p + 1 >= STORE_BYTES) ? 0 : p + 1;
  endfunction

  // Apply one host function to the mirror and return the reply it produces.
  function automatic out_item_t step_register_file(input in_item_t it);
    out_item_t   r;
    int unsigned i;
    r = '0;
    case (func_e'(it.func))
      FN_WR_REQ: begin
        addr_phase   = 1'b1;
        commit_armed = 1'b0;
      end
      FN_WR_DONE: begin
        if (addr_phase) begin
          byte_ptr   = it.data_byte % STORE_BYTES;
          start_mark = byte_ptr;
        end else begin
          staging_mem[byte_ptr] = it.data_byte;
          byte_ptr     = next_ptr(byte_ptr);
          commit_armed = 1'b1;
        end
        addr_phase = 1'b0;
      end
      FN_RD_REQ: begin
        // snapshot the shadow row when the pointer sits on a row boundary
        if (byte_ptr % ROW_BYTES == 0) begin
          for (i = byte_ptr; i < byte_ptr + ROW_BYTES && i < STORE_BYTES; i++)
            staging_mem[i] = shadow_mem[i];
        end
        if (byte_ptr == ALERT_OFFSET) alert_line = 1'b0;
        r.read_data  = staging_mem[byte_ptr];
        r.read_valid = 1'b1;
        byte_ptr     = next_ptr(byte_ptr);
        commit_armed = 1'b0;
      end
      FN_STOP: begin
        if (commit_armed) begin
          if (start_mark < byte_ptr) begin
            r.cmd_strobe = (start_mark == CMD_START);
            for (i = start_mark; i < byte_ptr; i++) shadow_mem[i] = staging_mem[i];
          end else if (start_mark > byte_ptr) begin
            for (i = 0; i < byte_ptr; i++) shadow_mem[i] = staging_mem[i];
            for (i = start_mark; i < STORE_BYTES; i++) shadow_mem[i] = staging_mem[i];
          end
          r.save_constants = (start_mark == CONST_START);
          commit_armed     = 1'b0;
        end
      end
      FN_LOCAL_WR: shadow_mem[it.local_address % STORE_BYTES] = it.data_byte;
      FN_ALERT: begin
        if (it.alert_bits == 8'h00) begin
          shadow_mem[ALERT_OFFSET % STORE_BYTES] = 8'h00;
          alert_line = 1'b0;
        end else begin
          shadow_mem[ALERT_OFFSET % STORE_BYTES] =
            shadow_mem[ALERT_OFFSET % STORE_BYTES] | it.alert_bits;
          alert_line = 1'b1;
        end
      end
      default: ;
    endcase
    r.alert_pin = alert_line;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches_o++;
    if (mismatches_o <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      for (int k = 0; k < STORE_BYTES; k++) begin
        staging_mem[k] = 8'h00;
        shadow_mem[k]  = 8'h00;
      end
      shadow_mem[LIMIT_ADDR % STORE_BYTES]       = LIMIT_DEFAULT[7:0];
      shadow_mem[(LIMIT_ADDR + 1) % STORE_BYTES] = LIMIT_DEFAULT[15:8];
      byte_ptr       = 0;
      start_mark     = 0;
      addr_phase     = 1'b0;
      commit_armed   = 1'b0;
      alert_line     = 1'b0;
      pending_replies.delete();
      mismatches_o   = 0;
      outstanding_o  = 0;
      transactions_o = 0;
      reads_o        = 0;
      cmd_pulses_o   = 0;
      save_pulses_o  = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got = rsp_i.item;
        if (pending_replies.size() == 0) begin
          flag_mismatch($sformatf("reply %h with no transaction outstanding", got));
        end else begin
          want = pending_replies.pop_front();
          if (got.read_data !== want.read_data)
            flag_mismatch($sformatf("read_data exp %h got %h", want.read_data, got.read_data));
          if (got.read_valid !== want.read_valid)
            flag_mismatch($sformatf("read_valid exp %b got %b", want.read_valid,
                                    got.read_valid));
          if (got.alert_pin !== want.alert_pin)
            flag_mismatch($sformatf("alert_pin exp %b got %b", want.alert_pin, got.alert_pin));
          if (got.cmd_strobe !== want.cmd_strobe)
            flag_mismatch($sformatf("cmd_strobe exp %b got %b", want.cmd_strobe,
                                    got.cmd_strobe));
          if (got.save_constants !== want.save_constants)
            flag_mismatch($sformatf("save_constants exp %b got %b", want.save_constants,
                                    got.save_constants));
        end
      end
      if (req_i.valid && req_i.ready) begin
        want = step_register_file(req_i.item);
        pending_replies.push_back(want);
        transactions_o++;
        if (want.read_valid) reads_o++;
        if (want.cmd_strobe) cmd_pulses_o++;
        if (want.save_constants) save_pulses_o++;
      end
      outstanding_o = pending_replies.size();
    end
  end

endmodule

### dv/tb_top.sv
module tb_top;
  import i2c_srf_pkg::*;

  localparam int unsigned ITEM_TARGET = 1750;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // idle odds out of a hundred, for both sides
  localparam int unsigned IDLE_PCT    = 29;
  // length of a burst that fills the store exactly once
  localparam int unsigned STORE_FILL  = 128;

  logic clk_i = 1'b0;
  logic rst_ni;

  i2c_srf_in_if  req_if ();
  i2c_srf_out_if rsp_if ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned transactions;
  int unsigned reads;
  int unsigned cmd_pulses;
  int unsigned save_pulses;

  int unsigned sent = 0;
  // calm: no idling on either side; hold_req: ask the receiver for a long hold-off
  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  always #4 clk_i = ~clk_i;

  i2c_slave_shadowed_register_file_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  i2c_srf_reply_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_if),
    .rsp_i          (rsp_if),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .transactions_o (transactions),
    .reads_o        (reads),
    .cmd_pulses_o   (cmd_pulses),
    .save_pulses_o  (save_pulses)
  );

  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  // Pick a pointer byte: favor command, constants and alert offsets, row
  // boundaries (with and without bit 7 set) and the top of the store.
  function automatic logic [7:0] pick_pointer();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return CONST_START;
      2:       return 8'h58;
      3:       return {1'($urandom), 3'($urandom), 4'h0};
      4:       return 8'h7E + 8'($urandom_range(0, 1));
      default: return rnd8();
    endcase
  endfunction

  // Offer one transaction and hold it until the block takes it. Idle gaps
  // drop valid first, so each step sees at most one update of valid.
  task automatic issue(input func_e f, input logic [7:0] d, input logic [6:0] la,
                       input logic [7:0] ab);
    in_item_t it;
    it.func          = f;
    it.data_byte     = d;
    it.local_address = la;
    it.alert_bits    = ab;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.item  <= it;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    sent++;
  endtask

  // Drop valid and wait until every reply the checker expects has arrived.
  task automatic drain_replies();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, a calm window without them, and one long
  // hold-off counted here while the sender keeps offering transactions.
  initial begin : receiver
    int unsigned hold_left;
    hold_left    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Guard against a hung block.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d replies outstanding", cycles, outstanding);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned n;
    bit          held;
    bit          paused;
    held          = 1'b0;
    paused        = 1'b0;
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.item   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    // Read completed and a stop without data: no state change.
    issue(FN_RD_DONE, 8'h00, 7'h00, 8'h00);
    issue(FN_STOP, 8'hFF, 7'h7F, 8'hFF);
    // Data byte with no write request in front: staged at pointer 0,
    // so the stop commits from address 0 and pulses the command strobe.
    issue(FN_WR_DONE, 8'hFF, 7'h00, 8'h00);
    issue(FN_STOP, 8'h00, 7'h00, 8'h00);
    // Pointer byte above the store size folds onto the constants block.
    issue(FN_WR_REQ, 8'h00, 7'h00, 8'h00);
    issue(FN_WR_DONE, 8'hB0, 7'h00, 8'h00);
    issue(FN_WR_DONE, 8'h00, 7'h00, 8'h00);
    issue(FN_STOP, 8'h00, 7'h00, 8'h00);
    // Local writes at both ends of the address range.
    issue(FN_LOCAL_WR, 8'hFF, 7'h7F, 8'h00);
    issue(FN_LOCAL_WR, 8'h00, 7'h00, 8'hFF);
    // Raise the alert with all bits, clear it, raise it again, then read
    // the alert byte so the line drops.
    issue(FN_ALERT, 8'h00, 7'h00, 8'hFF);
    issue(FN_ALERT, 8'hFF, 7'h7F, 8'h00);
    issue(FN_ALERT, 8'h00, 7'h00, 8'h55);
    issue(FN_WR_REQ, 8'h00, 7'h00, 8'h00);
    issue(FN_WR_DONE, 8'h58, 7'h00, 8'h00);
    issue(FN_RD_REQ, 8'h00, 7'h00, 8'h00);
    issue(FN_RD_DONE, 8'h00, 7'h00, 8'h00);
    // Wrapped commit across the end of the store.
    issue(FN_WR_REQ, 8'h00, 7'h00, 8'h00);
    issue(FN_WR_DONE, 8'h7F, 7'h00, 8'h00);
    issue(FN_WR_DONE, 8'h11, 7'h00, 8'h00);
    issue(FN_WR_DONE, 8'h22, 7'h00, 8'h00);
    issue(FN_STOP, 8'h00, 7'h00, 8'h00);
    // Row snapshot of the last row; the copy ends at the top of the store.
    issue(FN_WR_REQ, 8'h00, 7'h00, 8'h00);
    issue(FN_WR_DONE, 8'h70, 7'h00, 8'h00);
    issue(FN_RD_REQ, 8'h00, 7'h00, 8'h00);

    // Random part: mostly well-formed master writes and reads.
    while (sent < ITEM_TARGET) begin
      // Hold the receiver off once while transactions keep coming.
      if (!held && sent >= 600) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      // Pause the sender once until every reply is back.
      if (!paused && sent >= 900) begin
        paused = 1'b1;
        drain_replies();
      end
      calm = (sent >= 1100 && sent < 1400);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // Master write: pointer byte, data bytes, stop. Now and then a long
        // burst, sometimes exactly one full store, so pointer meets start mark.
        issue(FN_WR_REQ, rnd8(), 7'(rnd8()), rnd8());
        issue(FN_WR_DONE, pick_pointer(), 7'(rnd8()), rnd8());
        if ($urandom_range(0, 19) == 0)
          n = ($urandom_range(0, 2) == 0) ? STORE_FILL : $urandom_range(100, 140);
        else
          n = $urandom_range(0, 8);
        repeat (n) issue(FN_WR_DONE, rnd8(), 7'(rnd8()), rnd8());
        if ($urandom_range(0, 9) != 0) issue(FN_STOP, rnd8(), 7'(rnd8()), rnd8());
      end else if (pick < 70) begin
        // Master read: set the pointer (or continue from where it is), read
        // a run of bytes across row boundaries, then stop.
        if ($urandom_range(0, 3) != 0) begin
          issue(FN_WR_REQ, rnd8(), 7'(rnd8()), rnd8());
          issue(FN_WR_DONE, pick_pointer(), 7'(rnd8()), rnd8());
        end
        repeat ($urandom_range(1, 18)) begin
          issue(FN_RD_REQ, rnd8(), 7'(rnd8()), rnd8());
          if ($urandom_range(0, 1) == 0) issue(FN_RD_DONE, rnd8(), 7'(rnd8()), rnd8());
        end
        issue(FN_STOP, rnd8(), 7'(rnd8()), rnd8());
      end else if (pick < 82) begin
        issue(FN_LOCAL_WR, rnd8(),
              ($urandom_range(0, 3) == 0) ? 7'h58 : 7'(rnd8()), rnd8());
      end else if (pick < 90) begin
        issue(FN_ALERT, rnd8(), 7'(rnd8()),
              ($urandom_range(0, 3) == 0) ? 8'h00 : rnd8());
      end else begin
        // Noise: any function with any fields.
        repeat ($urandom_range(1, 4))
          issue(func_e'($urandom_range(0, 6)), rnd8(), 7'(rnd8()), rnd8());
      end
    end
    calm = 1'b0;

    // Let the last replies drain, then give the block time to settle.
    drain_replies();
    repeat (150) @(posedge clk_i);

    $display("Covered %0d transactions: %0d read requests, %0d command and %0d save strobes,",
             transactions, reads, cmd_pulses, save_pulses);
    $display("with one long receiver hold-off and one full drain.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
